@@ hdl/adc_step_sequencer_fifo_core_assert.svh @@
// ----------------------------------------------------------------------------
// ADC step sequencer assertion macros
// Shared wrappers for the concurrent checks of the sequencer core.
// ----------------------------------------------------------------------------
`ifndef ADC_STEP_SEQUENCER_FIFO_CORE_ASSERT_SVH
`define ADC_STEP_SEQUENCER_FIFO_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("adc step sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("adc step sequencer check failed");

`endif

@@ hdl/asf_pkg.sv @@
// ----------------------------------------------------------------------------
// ADC step sequencer package
// Register map, default sizes, field positions and shared types.
// ----------------------------------------------------------------------------
package asf_pkg;

	localparam int ASF_NUM_STEPS    = 16;
	localparam int ASF_NUM_CHANNELS = 8;
	localparam int ASF_FIFO_DEPTH   = 64;
	localparam int ASF_SAMPLE_BITS  = 12;

	localparam int ASF_REG_COUNT = 32;
	localparam int ASF_WORD_W    = 20;
	localparam int ASF_CH_W      = 4;

	localparam logic [4:0] ASF_R_SYS    = 5'd0;
	localparam logic [4:0] ASF_R_RAW    = 5'd1;
	localparam logic [4:0] ASF_R_STATUS = 5'd2;
	localparam logic [4:0] ASF_R_EN_SET = 5'd3;
	localparam logic [4:0] ASF_R_EN_CLR = 5'd4;
	localparam logic [4:0] ASF_R_CTRL   = 5'd5;
	localparam logic [4:0] ASF_R_STEPEN = 5'd6;
	localparam logic [4:0] ASF_R_CNT0   = 5'd7;
	localparam logic [4:0] ASF_R_CNT1   = 5'd8;
	localparam logic [4:0] ASF_R_DATA0  = 5'd9;
	localparam logic [4:0] ASF_R_DATA1  = 5'd10;
	localparam logic [4:0] ASF_R_REV    = 5'd11;
	localparam logic [4:0] ASF_R_STEP0  = 5'd12;

	localparam logic [31:0] ASF_REV_RESET       = 32'h4000_0001;
	localparam int          ASF_SAMPLE_MID      = 2048;
	localparam int          ASF_CH_LSB          = 19;
	localparam logic [3:0]  ASF_CH_MASK         = 4'hF;
	localparam int          ASF_FIFO_SEL_BIT    = 26;
	localparam int          ASF_CH_SHIFT        = 16;
	localparam logic [31:0] ASF_SOFT_RESET_MASK = 32'h2;
	localparam logic [31:0] ASF_EOS_MASK        = 32'h2;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_SAMPLE = 2'd2,
		KIND_NONE   = 2'd3
	} asf_kind_t;

	typedef struct packed {
		logic        wr;
		logic        eos;
		logic [4:0]  sel;
		logic [31:0] data;
	} asf_reg_cmd_t;

endpackage

@@ hdl/asf_fifo.sv @@
// ----------------------------------------------------------------------------
// ADC result FIFO
// Sample word store with push and pop pointers and a registered read port.
// ----------------------------------------------------------------------------
module asf_fifo import asf_pkg::*; #(
	parameter int FIFO_DEPTH = ASF_FIFO_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clr,
	input  logic                            push,
	input  logic [ASF_WORD_W-1:0]           push_word,
	input  logic                            pop,
	output logic [ASF_WORD_W-1:0]           pop_word,
	output logic [$clog2(FIFO_DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [ASF_WORD_W-1:0] mem [FIFO_DEPTH];
	logic [CW-1:0]         wr_q;
	logic [CW-1:0]         rd_q;
	logic                  do_push;
	logic                  do_pop;

	// Pushes only happen right after a clear, so the pointers never wrap.
	assign do_push = push && (wr_q != CW'(FIFO_DEPTH));
	assign do_pop  = pop && (wr_q != rd_q);
	assign count   = wr_q - rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else if (clr) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + CW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push && !clr) begin
			mem[wr_q[AW-1:0]] <= push_word;
		end
		if (do_pop) begin
			pop_word <= mem[rd_q[AW-1:0]];
		end
	end

endmodule

@@ hdl/asf_samples.sv @@
// ----------------------------------------------------------------------------
// ADC channel sample table and step unit
// Holds the analog sample of every channel and builds one tagged FIFO word
// from a step config.
// ----------------------------------------------------------------------------
module asf_samples import asf_pkg::*; #(
	parameter int NUM_CHANNELS = ASF_NUM_CHANNELS,
	parameter int SAMPLE_BITS  = ASF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clr,
	input  logic                   wr,
	input  logic [ASF_CH_W-1:0]    wr_channel,
	input  logic [SAMPLE_BITS-1:0] wr_sample,
	input  logic [31:0]            step_cfg,
	output logic [ASF_WORD_W-1:0]  step_word,
	output logic                   step_fifo
);

	localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_RESET = SAMPLE_BITS'(ASF_SAMPLE_MID);

	logic [SAMPLE_BITS-1:0] samples_q [NUM_CHANNELS];
	logic [ASF_CH_W-1:0]    cfg_ch;
	logic [ASF_CH_W-1:0]    step_ch;
	logic [SAMPLE_BITS-1:0] step_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				samples_q[i] <= SAMPLE_RESET;
			end
		end else if (clr) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				samples_q[i] <= SAMPLE_RESET;
			end
		end else if (wr) begin
			samples_q[wr_channel[CHW-1:0]] <= wr_sample;
		end
	end

	// A channel beyond the table is read as channel zero.
	always_comb begin
		cfg_ch = step_cfg[ASF_CH_LSB +: ASF_CH_W] & ASF_CH_MASK;
		if ({1'b0, cfg_ch} >= 5'(NUM_CHANNELS)) begin
			step_ch = '0;
		end else begin
			step_ch = cfg_ch;
		end
		step_sample = samples_q[step_ch[CHW-1:0]];
		step_word   = ASF_WORD_W'(32'(step_sample) | (32'(step_ch) << ASF_CH_SHIFT));
		step_fifo   = step_cfg[ASF_FIFO_SEL_BIT];
	end

endmodule

@@ hdl/asf_regs.sv @@
// ----------------------------------------------------------------------------
// ADC register file
// Bus registers with soft reset, write-1-to-clear status and enable aliases.
// ----------------------------------------------------------------------------
module asf_regs import asf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  asf_reg_cmd_t cmd,
	input  logic [4:0]   raddr,
	output logic [31:0]  rdata,
	output logic         seq_armed
);

	logic [31:0] regs_q [ASF_REG_COUNT];
	logic [31:0] regs_d [ASF_REG_COUNT];

	always_comb begin
		regs_d = regs_q;
		if (cmd.wr) begin
			unique case (cmd.sel)
				ASF_R_SYS: begin
					if ((cmd.data & ASF_SOFT_RESET_MASK) != '0) begin
						for (int i = 0; i < ASF_REG_COUNT; i++) begin
							regs_d[i] = '0;
						end
						regs_d[ASF_R_REV] = ASF_REV_RESET;
					end
					regs_d[ASF_R_SYS] = cmd.data;
				end
				ASF_R_STATUS: begin
					regs_d[ASF_R_STATUS] = regs_q[ASF_R_STATUS] & ~cmd.data;
					regs_d[ASF_R_RAW]    = regs_q[ASF_R_RAW] & ~cmd.data;
				end
				ASF_R_EN_SET: begin
					regs_d[ASF_R_EN_SET] = regs_q[ASF_R_EN_SET] | cmd.data;
				end
				// The clear alias itself is never stored and reads back as zero.
				ASF_R_EN_CLR: begin
					regs_d[ASF_R_EN_SET] = regs_q[ASF_R_EN_SET] & ~cmd.data;
				end
				default: begin
					regs_d[cmd.sel] = cmd.data;
				end
			endcase
		end
		if (cmd.eos) begin
			regs_d[ASF_R_RAW]    = regs_d[ASF_R_RAW] | ASF_EOS_MASK;
			regs_d[ASF_R_STATUS] = regs_d[ASF_R_STATUS] | ASF_EOS_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ASF_REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
			regs_q[ASF_R_REV] <= ASF_REV_RESET;
		end else begin
			regs_q <= regs_d;
		end
	end

	assign rdata     = regs_q[raddr];
	assign seq_armed = regs_q[ASF_R_CTRL][0];

endmodule

@@ hdl/adc_step_sequencer_fifo_core.sv @@
// ----------------------------------------------------------------------------
// ADC step sequencer core
// Bus front end, step sequencer and two result FIFOs of a step-based ADC.
// ----------------------------------------------------------------------------
// Each input request is a bus read, a bus write or an analog sample update
// (kind, reg_sel, write_data, channel) and yields exactly one read_data word.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. The core takes one request at a time and raises in_stall
// until that request's result has been placed in the output register.
// A plain read, write or sample update passes ST_EXEC and ST_RESP on its way
// to out_valid, a FIFO data read also ST_POP (registered FIFO memory port).
// A step-enable write that starts a sequence walks NUM_STEPS step configs
// through one shared step unit, one step per cycle, and ends via ST_SEQ_END.
// A new request is accepted in the cycle after the previous one finishes,
// even while its result still waits in the output register.
// When the receiver stalls, the finished result holds in the output
// register; a following result waits inside the core until it is taken.
// Asynchronous reset returns all registers, FIFO pointers and channel samples
// to reset values; a sysconfig write with bit 1 set does too, except sysconfig.
// ----------------------------------------------------------------------------
`include "adc_step_sequencer_fifo_core_assert.svh"

module adc_step_sequencer_fifo_core import asf_pkg::*; #(
	parameter int NUM_STEPS    = ASF_NUM_STEPS,
	parameter int NUM_CHANNELS = ASF_NUM_CHANNELS,
	parameter int FIFO_DEPTH   = ASF_FIFO_DEPTH,
	parameter int SAMPLE_BITS  = ASF_SAMPLE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [4:0]  reg_sel,
	input  logic [31:0] write_data,
	input  logic [3:0]  channel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data
);

	localparam int CW = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_SEQ,
		ST_SEQ_END,
		ST_RESP
	} state_t;

	state_t       state_q;
	asf_kind_t    kind_q;
	logic [4:0]   sel_q;
	logic [31:0]  data_q;
	logic [3:0]   chan_q;
	logic [3:0]   step_q;
	logic [31:0]  result_q;
	logic         out_valid_q;
	logic [31:0]  read_data_q;

	asf_reg_cmd_t          reg_cmd;
	logic [4:0]            raddr;
	logic [31:0]           regs_rdata;
	logic                  seq_armed;
	logic                  soft_rst;
	logic                  seq_start;
	logic                  fifo_clr;
	logic                  samp_wr;
	logic                  push0;
	logic                  push1;
	logic                  pop0;
	logic                  pop1;
	logic [ASF_WORD_W-1:0] pop_word0;
	logic [ASF_WORD_W-1:0] pop_word1;
	logic [CW-1:0]         count0;
	logic [CW-1:0]         count1;
	logic [ASF_WORD_W-1:0] step_word;
	logic                  step_fifo;
	logic [4:0]            en_idx;
	logic                  step_en;
	logic [31:0]           read_result;
	logic                  accept;
	logic                  out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign en_idx   = 5'(step_q) + 5'd1;
	assign step_en  = data_q[en_idx];

	always_comb begin
		reg_cmd      = '0;
		reg_cmd.sel  = sel_q;
		reg_cmd.data = data_q;
		raddr        = sel_q;
		soft_rst     = 1'b0;
		seq_start    = 1'b0;
		samp_wr      = 1'b0;
		push0        = 1'b0;
		push1        = 1'b0;
		pop0         = 1'b0;
		pop1         = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				unique case (kind_q)
					KIND_READ: begin
						pop0 = (sel_q == ASF_R_DATA0) && (count0 != '0);
						pop1 = (sel_q == ASF_R_DATA1) && (count1 != '0);
					end
					KIND_WRITE: begin
						reg_cmd.wr = 1'b1;
						soft_rst   = (sel_q == ASF_R_SYS) &&
							((data_q & ASF_SOFT_RESET_MASK) != '0);
						seq_start  = (sel_q == ASF_R_STEPEN) && seq_armed && (data_q != '0);
					end
					KIND_SAMPLE: begin
						samp_wr = ({1'b0, chan_q} < 5'(NUM_CHANNELS));
					end
					default: begin
					end
				endcase
			end
			ST_SEQ: begin
				raddr = ASF_R_STEP0 + 5'(step_q);
				push0 = step_en && !step_fifo;
				push1 = step_en && step_fifo;
			end
			ST_SEQ_END: begin
				reg_cmd.eos = (count0 != '0) || (count1 != '0);
			end
			default: begin
			end
		endcase
	end

	assign fifo_clr = soft_rst || seq_start;

	// An empty data read returns zero rather than the stored register value.
	always_comb begin
		unique case (sel_q)
			ASF_R_CNT0:  read_result = 32'(count0);
			ASF_R_CNT1:  read_result = 32'(count1);
			ASF_R_DATA0: read_result = '0;
			ASF_R_DATA1: read_result = '0;
			default:     read_result = regs_rdata;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= asf_kind_t'(kind);
			sel_q  <= reg_sel;
			data_q <= write_data;
			chan_q <= channel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			result_q    <= '0;
			out_valid_q <= 1'b0;
			read_data_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_RESP)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					step_q   <= '0;
					result_q <= (kind_q == KIND_READ) ? read_result : '0;
					if (pop0 || pop1) begin
						state_q <= ST_POP;
					end else if (seq_start) begin
						state_q <= ST_SEQ;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_POP: begin
					result_q <= (sel_q == ASF_R_DATA0) ? 32'(pop_word0) : 32'(pop_word1);
					state_q  <= ST_RESP;
				end
				ST_SEQ: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'(NUM_STEPS - 1)) begin
						state_q <= ST_SEQ_END;
					end
				end
				ST_SEQ_END: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						read_data_q <= result_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	asf_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (reg_cmd),
		.raddr     (raddr),
		.rdata     (regs_rdata),
		.seq_armed (seq_armed)
	);

	asf_samples #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_samples (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (soft_rst),
		.wr         (samp_wr),
		.wr_channel (chan_q),
		.wr_sample  (data_q[SAMPLE_BITS-1:0]),
		.step_cfg   (regs_rdata),
		.step_word  (step_word),
		.step_fifo  (step_fifo)
	);

	asf_fifo #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_fifo0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (fifo_clr),
		.push      (push0),
		.push_word (step_word),
		.pop       (pop0),
		.pop_word  (pop_word0),
		.count     (count0)
	);

	asf_fifo #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_fifo1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (fifo_clr),
		.push      (push1),
		.push_word (step_word),
		.pop       (pop1),
		.pop_word  (pop_word1),
		.count     (count1)
	);

	`ASF_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == ST_EXEC)
	`ASF_ASSERT_NEXT(a_resp_loads, clk, arst_n, (state_q == ST_RESP) && out_free, out_valid_q && (state_q == ST_IDLE))
	`ASF_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, (count0 <= CW'(FIFO_DEPTH)) && (count1 <= CW'(FIFO_DEPTH)))
	`ASF_ASSERT_NEXT(a_seq_clears, clk, arst_n, seq_start, (count0 == '0) && (count1 == '0) && (state_q == ST_SEQ))

endmodule
